@@ design/qvr_pkg.sv @@
// Package for the quaternion vector rotation core: widths, types and limits.
package qvr_pkg;

    // Field widths
    localparam int QUAT_WIDTH   = 16;
    localparam int VECTOR_WIDTH = 16;
    localparam int ROT_WIDTH    = 18;
    localparam int FRAC_SHIFT   = 15;

    // Quaternion product (Q2.30) and the doubled sum it feeds
    localparam int PROD_WIDTH   = 2 * QUAT_WIDTH;
    localparam int DBL_WIDTH    = PROD_WIDTH + 2;
    // Matrix entry after the Q.15 shift
    localparam int ENTRY_WIDTH  = DBL_WIDTH - FRAC_SHIFT;
    // Entry times vector component, and the sum of three of them
    localparam int MPROD_WIDTH  = ENTRY_WIDTH + VECTOR_WIDTH;
    localparam int ACC_WIDTH    = MPROD_WIDTH + 2;
    localparam int SHR_WIDTH    = ACC_WIDTH - FRAC_SHIFT;

    // Saturation limits of a rotated component
    localparam int ROT_MAX      = (1 << (ROT_WIDTH - 1)) - 1;
    localparam int ROT_MIN      = -(1 << (ROT_WIDTH - 1));

    localparam int NUM_ENTRIES  = 9;
    localparam int NUM_AXES     = 3;

    typedef logic signed [QUAT_WIDTH-1:0]   t_quat;
    typedef logic signed [VECTOR_WIDTH-1:0] t_vec;
    typedef logic signed [ROT_WIDTH-1:0]    t_rot;
    typedef logic signed [PROD_WIDTH-1:0]   t_prod;
    typedef logic signed [DBL_WIDTH-1:0]    t_dbl;
    typedef logic signed [ENTRY_WIDTH-1:0]  t_entry;
    typedef logic signed [MPROD_WIDTH-1:0]  t_mprod;
    typedef logic signed [ACC_WIDTH-1:0]    t_acc;
    typedef logic signed [SHR_WIDTH-1:0]    t_shr;

endpackage

@@ design/qvr_if.sv @@
// Stream interfaces of the rotation core: input word and result word.
interface qvr_in_if
    import qvr_pkg::*;
;
    logic  valid;
    logic  ready;
    t_quat quat_w;
    t_quat quat_x;
    t_quat quat_y;
    t_quat quat_z;
    t_vec  vec_x;
    t_vec  vec_y;
    t_vec  vec_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

interface qvr_out_if
    import qvr_pkg::*;
;
    logic valid;
    logic ready;
    t_rot rot_x;
    t_rot rot_y;
    t_rot rot_z;
    logic clipped;

    modport source (
        output valid, rot_x, rot_y, rot_z, clipped,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z, clipped,
        output ready
    );
endinterface

@@ design/qvr_matrix.sv @@
// Two-stage rotation matrix builder: quaternion products, then entry sums.
module qvr_matrix
    import qvr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_quat  i_w,
    input  t_quat  i_x,
    input  t_quat  i_y,
    input  t_quat  i_z,
    output t_entry o_m [NUM_ENTRIES]
);

    // Stage 1 registers: the ten distinct products
    t_prod r_ww, r_xx, r_yy, r_zz;
    t_prod r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;
    // Stage 2 registers: matrix entries
    t_entry r_m [NUM_ENTRIES];
    t_entry n_m [NUM_ENTRIES];

    // a + b - c - d, then floor shift to Q.15
    function automatic t_entry diag_entry(t_prod a, t_prod b, t_prod c, t_prod d);
        t_dbl s;
        s = t_dbl'(a) + t_dbl'(b) - t_dbl'(c) - t_dbl'(d);
        return s[DBL_WIDTH-1:FRAC_SHIFT];
    endfunction

    // 2 * (a +/- b), then floor shift to Q.15
    function automatic t_entry off_entry(t_prod a, t_prod b, logic sub);
        t_dbl s;
        s = sub ? (t_dbl'(a) - t_dbl'(b)) : (t_dbl'(a) + t_dbl'(b));
        s = s <<< 1;
        return s[DBL_WIDTH-1:FRAC_SHIFT];
    endfunction

    // Products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= i_w * i_w;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_zw <= i_z * i_w;
            r_xz <= i_x * i_z;
            r_yw <= i_y * i_w;
            r_yz <= i_y * i_z;
            r_xw <= i_x * i_w;
        end
    end

    // Entry sums, row major
    always_comb begin
        n_m[0] = diag_entry(r_ww, r_xx, r_yy, r_zz);
        n_m[1] = off_entry(r_xy, r_zw, 1'b1);
        n_m[2] = off_entry(r_xz, r_yw, 1'b0);
        n_m[3] = off_entry(r_xy, r_zw, 1'b0);
        n_m[4] = diag_entry(r_ww, r_yy, r_xx, r_zz);
        n_m[5] = off_entry(r_yz, r_xw, 1'b1);
        n_m[6] = off_entry(r_xz, r_yw, 1'b1);
        n_m[7] = off_entry(r_yz, r_xw, 1'b0);
        n_m[8] = diag_entry(r_ww, r_zz, r_xx, r_yy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= n_m;
        end
    end

    assign o_m = r_m;

endmodule

@@ design/quaternion_vector_rotation_core.sv @@
// Top level: quaternion to matrix, matrix times vector, shift and saturate.
//
//   channel   dir   handshake          payload
//   i_in      in    valid / ready      quat_w/x/y/z (Q1.15), vec_x/y/z
//   o_out     out   valid / ready      rot_x/y/z (18 b, saturated), clipped
//
// Four register stages: products, matrix entries, entry*vector, sum+saturate.
// One word per cycle while the output is not stalled.
// The whole pipe advances whenever the output register is empty or being taken,
// so i_in.ready follows o_out.ready and a stall freezes every stage in place.
// Reset clears only the stage valid bits.
module quaternion_vector_rotation_core
    import qvr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    qvr_in_if.sink     i_in,
    qvr_out_if.source  o_out
);

    localparam int NUM_STAGES = 4;

    logic               w_en;
    logic [NUM_STAGES-1:0] r_vld;
    t_entry             w_m [NUM_ENTRIES];
    // Vector delayed to line up with the matrix entries
    t_vec               r_v1 [NUM_AXES];
    t_vec               r_v2 [NUM_AXES];
    // Stage 3: entry times vector component
    t_mprod             r_p [NUM_ENTRIES];
    // Stage 4: output word
    t_rot               r_rot [NUM_AXES];
    logic               r_clip;
    t_rot               n_rot [NUM_AXES];
    logic               n_clip;

    // Global advance
    assign w_en       = !r_vld[NUM_STAGES-1] || o_out.ready;
    assign i_in.ready = w_en;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_in.valid};
        end
    end

    // Stages 1 and 2
    qvr_matrix u_matrix (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_w   (i_in.quat_w),
        .i_x   (i_in.quat_x),
        .i_y   (i_in.quat_y),
        .i_z   (i_in.quat_z),
        .o_m   (w_m)
    );

    // Vector delay line
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v1[0] <= i_in.vec_x;
            r_v1[1] <= i_in.vec_y;
            r_v1[2] <= i_in.vec_z;
            r_v2    <= r_v1;
        end
    end

    // Stage 3: nine products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_p[i] <= w_m[i] * r_v2[i % NUM_AXES];
            end
        end
    end

    // Stage 4: row sums, floor shift, saturate
    always_comb begin
        t_acc acc;
        t_shr shr;
        n_clip = 1'b0;
        for (int r = 0; r < NUM_AXES; r++) begin
            acc = t_acc'(r_p[NUM_AXES*r]) + t_acc'(r_p[NUM_AXES*r+1])
                + t_acc'(r_p[NUM_AXES*r+2]);
            shr = acc[ACC_WIDTH-1:FRAC_SHIFT];
            if (shr > t_shr'(ROT_MAX)) begin
                n_rot[r] = t_rot'(ROT_MAX);
                n_clip   = 1'b1;
            end else if (shr < t_shr'(ROT_MIN)) begin
                n_rot[r] = t_rot'(ROT_MIN);
                n_clip   = 1'b1;
            end else begin
                n_rot[r] = shr[ROT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rot  <= n_rot;
            r_clip <= n_clip;
        end
    end

    assign o_out.valid   = r_vld[NUM_STAGES-1];
    assign o_out.rot_x   = r_rot[0];
    assign o_out.rot_y   = r_rot[1];
    assign o_out.rot_z   = r_rot[2];
    assign o_out.clipped = r_clip;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the quaternion vector rotation core.
module tb_top
    import qvr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS  = 850;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int PIPE_LATENCY  = 4;
    localparam int NUM_DIRECTED  = 20;
    localparam int STEADY_FIRST  = 300;
    localparam int STEADY_LAST   = 450;
    localparam int DRAIN_AT      = 600;
    localparam int IDLE_PERCENT  = 17;

    // Random part shapes
    localparam int PART_FULL  = 0;
    localparam int PART_HALF  = 1;
    localparam int PART_SMALL = 2;
    localparam int PART_EDGE  = 3;
    localparam int PART_LARGE = 4;

    typedef struct packed {
        t_quat w;
        t_quat x;
        t_quat y;
        t_quat z;
        t_vec  vx;
        t_vec  vy;
        t_vec  vz;
    } quat_word_t;

    typedef struct packed {
        t_rot rot_x;
        t_rot rot_y;
        t_rot rot_z;
        logic clipped;
    } rot_word_t;

    // Directed row: quaternion, vector, and an optional hand-worked result
    typedef struct {
        int qw, qx, qy, qz;
        int vx, vy, vz;
        bit typed;
        int ex, ey, ez, ec;
    } directed_row_t;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // minus one scalar: identity, vector passes through
        '{-32768, 0, 0, 0, -32768, 32767, 1, 1'b1, -32768, 32767, 1, 0},
        // zero quaternion collapses everything
        '{0, 0, 0, 0, 32767, -32768, -1, 1'b1, 0, 0, 0, 0},
        // pure axis quaternions at minus one: 180 degree turns
        '{0, -32768, 0, 0, 100, 200, -300, 1'b1, 100, -200, 300, 0},
        '{0, 0, -32768, 0, 100, 200, -300, 1'b1, -100, 200, 300, 0},
        '{0, 0, 0, -32768, 100, 200, -300, 1'b1, -100, -200, -300, 0},
        // oversized quaternion, saturates high and low
        '{0, -32768, -32768, -32768, -32768, 32767, 32767, 1'b1,
          131071, -32769, -32769, 1},
        '{0, -32768, -32768, -32768, 32767, -32768, -32768, 1'b1,
          -131072, 32766, 32766, 1},
        // all minus one: lands exactly on the low limit, no clip
        '{-32768, -32768, -32768, -32768, -32768, 32767, -32768, 1'b1,
          -131072, -131072, 131068, 0},
        '{32767, 0, 0, 0, 32767, -32768, -1, 1'b0, 0, 0, 0, 0},
        '{23170, 0, 0, 23170, 1000, 0, 0, 1'b0, 0, 0, 0, 0},
        '{23170, 23170, 0, 0, 0, 1000, -1000, 1'b0, 0, 0, 0, 0},
        '{16384, 16384, 16384, 16384, 12345, -12345, 777, 1'b0, 0, 0, 0, 0},
        '{-1, -1, -1, -1, -1, -1, -1, 1'b0, 0, 0, 0, 0},
        '{1, 0, 0, 0, 32767, -32768, 5, 1'b0, 0, 0, 0, 0},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0, 0, 0, 0, 0},
        '{-32768, 32767, -32768, 32767, -32768, -32768, -32768, 1'b0,
          0, 0, 0, 0},
        '{0, 23170, 23170, 0, -5000, 3000, 20000, 1'b0, 0, 0, 0, 0},
        '{12000, -20000, 8000, -15000, -32768, 32767, 0, 1'b0, 0, 0, 0, 0},
        '{32767, -32768, 32767, -32768, 1, -1, 32767, 1'b0, 0, 0, 0, 0},
        '{-23170, 0, 23170, 0, -1, 0, 1, 1'b0, 0, 0, 0, 0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   steady  = 1'b0;

    int errors          = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int clipped_seen    = 0;
    int cycle_count     = 0;

    rot_word_t rotations_due [$];

    qvr_in_if  in_if ();
    qvr_out_if out_if ();

    quaternion_vector_rotation_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Quaternion to matrix, matrix times vector, floor shift, saturate
    function automatic rot_word_t rotate_vector(input quat_word_t s);
        longint w, x, y, z, ww, xx, yy, zz, acc;
        longint v [3];
        longint m [9];
        longint r [3];
        rot_word_t res;
        int i;
        w = $signed(s.w);
        x = $signed(s.x);
        y = $signed(s.y);
        z = $signed(s.z);
        v[0] = $signed(s.vx);
        v[1] = $signed(s.vy);
        v[2] = $signed(s.vz);
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        m[0] = (ww + xx - yy - zz) >>> FRAC_SHIFT;
        m[1] = (2 * (x * y - z * w)) >>> FRAC_SHIFT;
        m[2] = (2 * (x * z + y * w)) >>> FRAC_SHIFT;
        m[3] = (2 * (x * y + z * w)) >>> FRAC_SHIFT;
        m[4] = (ww - xx + yy - zz) >>> FRAC_SHIFT;
        m[5] = (2 * (y * z - x * w)) >>> FRAC_SHIFT;
        m[6] = (2 * (x * z - y * w)) >>> FRAC_SHIFT;
        m[7] = (2 * (y * z + x * w)) >>> FRAC_SHIFT;
        m[8] = (ww - xx - yy + zz) >>> FRAC_SHIFT;
        res.clipped = 1'b0;
        for (i = 0; i < NUM_AXES; i++) begin
            acc  = m[3*i] * v[0] + m[3*i+1] * v[1] + m[3*i+2] * v[2];
            r[i] = acc >>> FRAC_SHIFT;
            if (r[i] > ROT_MAX) begin
                r[i] = ROT_MAX;
                res.clipped = 1'b1;
            end else if (r[i] < ROT_MIN) begin
                r[i] = ROT_MIN;
                res.clipped = 1'b1;
            end
        end
        res.rot_x = t_rot'(r[0]);
        res.rot_y = t_rot'(r[1]);
        res.rot_z = t_rot'(r[2]);
        return res;
    endfunction

    // One 16-bit field value of the requested shape
    function automatic int pick_part(input int shape);
        int val;
        case (shape)
            PART_FULL:  val = int'($urandom_range(0, 65535)) - 32768;
            PART_HALF:  val = int'($urandom_range(0, 32767)) - 16384;
            PART_SMALL: val = int'($urandom_range(0, 4000)) - 2000;
            PART_LARGE: begin
                if ($urandom_range(0, 1) == 1)
                    val = 32767 - int'($urandom_range(0, 2767));
                else
                    val = -32768 + int'($urandom_range(0, 2768));
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       val = -32768;
                    1:       val = -1;
                    2:       val = 0;
                    3:       val = 1;
                    default: val = 32767;
                endcase
            end
        endcase
        return val;
    endfunction

    function automatic quat_word_t make_word(input int p [7]);
        quat_word_t s;
        s.w  = t_quat'(p[0]);
        s.x  = t_quat'(p[1]);
        s.y  = t_quat'(p[2]);
        s.z  = t_quat'(p[3]);
        s.vx = t_vec'(p[4]);
        s.vy = t_vec'(p[5]);
        s.vz = t_vec'(p[6]);
        return s;
    endfunction

    // Present one word after a random idle gap (none while steady), expectation queued on accept
    task automatic send_word(input quat_word_t s, input rot_word_t want);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
            gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.quat_w <= s.w;
        in_if.quat_x <= s.x;
        in_if.quat_y <= s.y;
        in_if.quat_z <= s.z;
        in_if.vec_x  <= s.vx;
        in_if.vec_y  <= s.vy;
        in_if.vec_z  <= s.vz;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        rotations_due.push_back(want);
        words_sent++;
    endtask

    // Hold off the sender until every queued result has come back
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (rotations_due.size() != 0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Receiver stalls
    always @(posedge i_clk)
        out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Result checker
    always @(posedge i_clk) begin : check_results
        rot_word_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (rotations_due.size() == 0) begin
                $error("result word with no rotation pending");
                errors++;
            end else begin
                want = rotations_due.pop_front();
                check_field("rot_x", $signed(want.rot_x), $signed(out_if.rot_x));
                check_field("rot_y", $signed(want.rot_y), $signed(out_if.rot_y));
                check_field("rot_z", $signed(want.rot_z), $signed(out_if.rot_z));
                check_field("clipped", want.clipped, out_if.clipped);
                results_checked++;
                if (out_if.clipped)
                    clipped_seen++;
            end
        end
    end

    initial begin : stimulus
        quat_word_t s;
        rot_word_t  want;
        int         p [7];
        int         n, k, shape, axis;
        in_if.valid  = 1'b0;
        in_if.quat_w = '0;
        in_if.quat_x = '0;
        in_if.quat_y = '0;
        in_if.quat_z = '0;
        in_if.vec_x  = '0;
        in_if.vec_y  = '0;
        in_if.vec_z  = '0;
        out_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (n = 0; n < NUM_DIRECTED; n++) begin
            p = '{directed_rows[n].qw, directed_rows[n].qx, directed_rows[n].qy,
                  directed_rows[n].qz, directed_rows[n].vx, directed_rows[n].vy,
                  directed_rows[n].vz};
            s = make_word(p);
            if (directed_rows[n].typed) begin
                want.rot_x   = t_rot'(directed_rows[n].ex);
                want.rot_y   = t_rot'(directed_rows[n].ey);
                want.rot_z   = t_rot'(directed_rows[n].ez);
                want.clipped = directed_rows[n].ec[0];
            end else begin
                want = rotate_vector(s);
            end
            send_word(s, want);
        end
        drain_results();

        // Random words: mostly full-range and half-scale, some near one axis
        for (n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= STEADY_FIRST && n < STEADY_LAST);
            if (n == DRAIN_AT)
                drain_results();
            k = $urandom_range(0, 99);
            if (k < 40)
                shape = PART_FULL;
            else if (k < 70)
                shape = PART_HALF;
            else if (k < 90)
                shape = PART_SMALL;
            else
                shape = PART_EDGE;
            for (k = 0; k < 4; k++)
                p[k] = pick_part(shape);
            // dominant single axis over small remainder
            if (shape == PART_SMALL) begin
                axis = $urandom_range(0, 3);
                p[axis] = pick_part(PART_LARGE);
            end
            for (k = 4; k < 7; k++)
                p[k] = pick_part(($urandom_range(0, 99) < 85) ? PART_FULL : PART_EDGE);
            s = make_word(p);
            send_word(s, rotate_vector(s));
        end
        steady = 1'b0;
        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("Sent %0d words (%0d from the directed table), checked %0d results",
                 words_sent, NUM_DIRECTED, results_checked);
        $display("%0d results came back saturated", clipped_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
